// ----- rtl/core/htwd_pkg.sv -----
// Package for the Huffman tree-walk decoder: node table geometry, node entry type,
// command and register codes, result type. No dependencies.
package htwd_pkg;

	localparam int MAX_NODES   = 511;
	localparam int SYMBOL_BITS = 8;
	localparam int NODE_AW     = $clog2(MAX_NODES);
	localparam int CHILD_W     = 10;
	localparam int PIXEL_W     = 8;
	localparam int COUNT_W     = 24;
	localparam int PDATA_W     = 32;
	localparam int PADDR_W     = 3;

	localparam logic [NODE_AW:0]         MAX_IDX    = (NODE_AW + 1)'(MAX_NODES);
	localparam logic signed [CHILD_W-1:0] NO_CHILD  = -10'sd1;
	localparam logic [NODE_AW-1:0]       ROOT_RESET = NODE_AW'(510);
	localparam logic [COUNT_W-1:0]       IMG_RESET  = COUNT_W'(1);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_BIT   = 1'b1;

	localparam logic REG_ROOT = 1'b0;
	localparam logic REG_IMG  = 1'b1;

	typedef struct packed {
		logic signed [CHILD_W-1:0] left;
		logic signed [CHILD_W-1:0] right;
		logic [SYMBOL_BITS-1:0]    sym;
	} node_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_value;
		logic               last_of_image;
		logic               malformed;
	} res_t;

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_ROOT = 2'b10
	} state_t;

endpackage

// ----- rtl/core/htwd_if.sv -----
// Valid/ready channels of the Huffman tree-walk decoder: code/node-write beats in,
// pixel beats out. Depends on htwd_pkg.
interface htwd_in_if import htwd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [NODE_AW-1:0]        node_index;
	logic signed [CHILD_W-1:0] left_child;
	logic signed [CHILD_W-1:0] right_child;
	logic [PIXEL_W-1:0]        node_symbol;
	logic                      code_bit;

	modport source (output valid, command, node_index, left_child, right_child, node_symbol,
		code_bit, input ready);
	modport sink (input valid, command, node_index, left_child, right_child, node_symbol,
		code_bit, output ready);
endinterface

interface htwd_out_if import htwd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel_value;
	logic               last_of_image;
	logic               malformed;

	modport source (output valid, pixel_value, last_of_image, malformed, input ready);
	modport sink (input valid, pixel_value, last_of_image, malformed, output ready);
endinterface

// ----- rtl/core/htwd_node_mem.sv -----
// Node table: one write port, two registered read ports, write-to-read bypass.
// Depends on htwd_pkg.
module htwd_node_mem import htwd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [NODE_AW-1:0] waddr,
	input  node_t              wdata,
	input  logic [NODE_AW-1:0] raddr_l,
	input  logic [NODE_AW-1:0] raddr_r,
	output node_t              rdata_l,
	output node_t              rdata_r
);

	node_t mem [MAX_NODES];
	node_t rd_l_q;
	node_t rd_r_q;
	node_t wdata_q;
	logic  fwd_l_q;
	logic  fwd_r_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_l_q  <= mem[raddr_l];
		rd_r_q  <= mem[raddr_r];
		wdata_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_l_q <= 1'b0;
			fwd_r_q <= 1'b0;
		end else begin
			fwd_l_q <= we && (waddr == raddr_l);
			fwd_r_q <= we && (waddr == raddr_r);
		end
	end

	assign rdata_l = fwd_l_q ? wdata_q : rd_l_q;
	assign rdata_r = fwd_r_q ? wdata_q : rd_r_q;

endmodule

// ----- rtl/core/huffman_tree_walk_decoder_unit.sv -----
// Huffman tree-walk decoder top level. Depends on htwd_pkg, htwd_if, htwd_node_mem.
// Throughput: one beat per cycle while the skid register is empty and no root fetch is
// pending; both children of the current node are prefetched from the two read ports of
// the node memory. Two-entry output buffer: a pixel is registered into the output reg,
// or the skid reg if that is occupied. A root_index write holds off input for the fetch.
// Reset: root 510, image size 1, pixel count 0, walk at root; node table not cleared.
module huffman_tree_walk_decoder_unit import htwd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	htwd_in_if.sink            code,
	htwd_out_if.source         pixel,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	state_t             state_q, state_n;
	logic [NODE_AW-1:0] root_q;
	logic [COUNT_W-1:0] img_q;
	logic [COUNT_W-1:0] pix_q;
	logic [NODE_AW-1:0] cur_q, cur_n;

	logic signed [CHILD_W-1:0] chl_q, chr_q, chl_n, chr_n;
	logic signed [CHILD_W-1:0] rootl_q, rootr_q, rootl_n, rootr_n;

	res_t out_q, skid_q, res_n;
	logic out_v_q, skid_v_q;

	logic               cfg_wr, cfg_idx, root_wr;
	logic               in_rdy, acc, is_wr, wr_ok, is_bit;
	logic [NODE_AW-1:0] raddr_l, raddr_r;
	node_t              rd_l, rd_r, ent, wnode;

	logic signed [CHILD_W-1:0] child;
	logic                      bad_cur, bad_child, l_none, r_none, leaf, one_kid;
	logic                      emit, descend, bad, last, pop;
	logic [COUNT_W:0]          cnt;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[PADDR_W-1];
	assign root_wr = cfg_wr && (cfg_idx == REG_ROOT);

	always_comb begin
		case (cfg_idx)
			REG_ROOT: prdata = PDATA_W'(root_q);
			REG_IMG:  prdata = PDATA_W'(img_q);
			default:  prdata = '0;
		endcase
	end

	assign in_rdy     = (state_q == ST_RUN) && !skid_v_q;
	assign code.ready = in_rdy;
	assign acc        = code.valid && in_rdy;
	assign is_wr      = acc && (code.command == CMD_WRITE);
	assign is_bit     = acc && (code.command == CMD_BIT);
	assign wr_ok      = is_wr && ({1'b0, code.node_index} < MAX_IDX);

	assign wnode.left  = code.left_child;
	assign wnode.right = code.right_child;
	assign wnode.sym   = SYMBOL_BITS'(code.node_symbol);

	htwd_node_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (wr_ok),
		.waddr   (code.node_index),
		.wdata   (wnode),
		.raddr_l (raddr_l),
		.raddr_r (raddr_r),
		.rdata_l (rd_l),
		.rdata_r (rd_r)
	);

	assign child     = code.code_bit ? chr_q : chl_q;
	assign ent       = code.code_bit ? rd_r : rd_l;
	assign bad_cur   = {1'b0, cur_q} >= MAX_IDX;
	assign bad_child = child[CHILD_W-1] || ({1'b0, child[NODE_AW-1:0]} >= MAX_IDX);
	assign l_none    = ent.left == NO_CHILD;
	assign r_none    = ent.right == NO_CHILD;
	assign leaf      = l_none && r_none;
	assign one_kid   = l_none ^ r_none;
	assign emit      = is_bit && (bad_cur || bad_child || leaf || one_kid);
	assign descend   = is_bit && !emit;
	assign bad       = bad_cur || bad_child || !leaf;

	assign cnt  = {1'b0, pix_q} + (COUNT_W + 1)'(1);
	assign last = cnt >= {1'b0, img_q};

	assign res_n.pixel_value   = bad ? '0 : PIXEL_W'(ent.sym);
	assign res_n.last_of_image = last;
	assign res_n.malformed     = bad;

	always_comb begin
		state_n = state_q;
		cur_n   = cur_q;
		chl_n   = chl_q;
		chr_n   = chr_q;
		rootl_n = rootl_q;
		rootr_n = rootr_q;
		if (state_q == ST_ROOT) begin
			chl_n   = rd_l.left;
			chr_n   = rd_l.right;
			rootl_n = rd_l.left;
			rootr_n = rd_l.right;
			state_n = ST_RUN;
		end
		if (wr_ok) begin
			if (code.node_index == cur_q) begin
				chl_n = code.left_child;
				chr_n = code.right_child;
			end
			if (code.node_index == root_q) begin
				rootl_n = code.left_child;
				rootr_n = code.right_child;
			end
		end
		if (emit) begin
			cur_n = root_q;
			chl_n = rootl_q;
			chr_n = rootr_q;
		end else if (descend) begin
			cur_n = child[NODE_AW-1:0];
			chl_n = ent.left;
			chr_n = ent.right;
		end
		raddr_l = chl_n[NODE_AW-1:0];
		raddr_r = chr_n[NODE_AW-1:0];
		if (root_wr) begin
			cur_n   = pwdata[NODE_AW-1:0];
			raddr_l = pwdata[NODE_AW-1:0];
			state_n = ST_ROOT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			root_q  <= ROOT_RESET;
			img_q   <= IMG_RESET;
			pix_q   <= '0;
			cur_q   <= ROOT_RESET;
		end else begin
			state_q <= state_n;
			cur_q   <= cur_n;
			if (root_wr) begin
				root_q <= pwdata[NODE_AW-1:0];
			end
			if (cfg_wr && (cfg_idx == REG_IMG)) begin
				img_q <= pwdata[COUNT_W-1:0];
			end
			if (emit) begin
				pix_q <= last ? '0 : cnt[COUNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		chl_q   <= chl_n;
		chr_q   <= chr_n;
		rootl_q <= rootl_n;
		rootr_q <= rootr_n;
	end

	assign pop = out_v_q && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (pop) begin
					skid_v_q <= 1'b0;
				end
			end else if (emit) begin
				if (out_v_q && !pop) begin
					skid_v_q <= 1'b1;
				end else begin
					out_v_q <= 1'b1;
				end
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (emit) begin
			if (out_v_q && !pop) begin
				skid_q <= res_n;
			end else begin
				out_q <= res_n;
			end
		end
	end

	assign pixel.valid         = out_v_q;
	assign pixel.pixel_value   = out_q.pixel_value;
	assign pixel.last_of_image = out_q.last_of_image;
	assign pixel.malformed     = out_q.malformed;

endmodule

// ----- bench/tb_huffman_tree_walk_decoder_unit.sv -----
// Testbench for huffman_tree_walk_decoder_unit: random code trees, code-bit streams and
// node writes, with a scoreboard that predicts every pixel beat and checks registers.
// Depends on htwd_pkg, htwd_in_if, htwd_out_if and the decoder RTL.
module tb_huffman_tree_walk_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import htwd_pkg::*;

	typedef struct {
		logic                      command;
		logic [NODE_AW-1:0]        node_index;
		logic signed [CHILD_W-1:0] left_child;
		logic signed [CHILD_W-1:0] right_child;
		logic [PIXEL_W-1:0]        node_symbol;
		logic                      code_bit;
	} code_beat_t;

	class pixel_scoreboard;
		bit signed [CHILD_W-1:0] left_tbl [MAX_NODES];
		bit signed [CHILD_W-1:0] right_tbl [MAX_NODES];
		bit [SYMBOL_BITS-1:0]    sym_tbl [MAX_NODES];
		bit [NODE_AW-1:0]        root;
		bit [COUNT_W-1:0]        img_size;
		bit [NODE_AW-1:0]        walk_node;
		bit [COUNT_W-1:0]        count;
		res_t                    pending[$];
		int                      errors;

		function new();
			foreach (left_tbl[i]) begin
				left_tbl[i] = '0;
				right_tbl[i] = '0;
				sym_tbl[i] = '0;
			end
			root = ROOT_RESET;
			img_size = IMG_RESET;
			walk_node = root;
			count = '0;
			errors = 0;
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void set_reg(logic idx, logic [PDATA_W-1:0] v);
			if (idx == REG_ROOT) begin
				root = v[NODE_AW-1:0];
				walk_node = root;
			end else begin
				img_size = v[COUNT_W-1:0];
			end
		endfunction

		function logic [PDATA_W-1:0] reg_value(logic idx);
			return (idx == REG_ROOT) ? PDATA_W'(root) : PDATA_W'(img_size);
		endfunction

		function void emit(bit [SYMBOL_BITS-1:0] sym, bit bad);
			bit [COUNT_W:0] n;
			res_t r;
			n = count + 1'b1;
			r.pixel_value = bad ? '0 : PIXEL_W'(sym);
			r.last_of_image = (n >= img_size);
			r.malformed = bad;
			count = r.last_of_image ? '0 : n[COUNT_W-1:0];
			walk_node = root;
			pending.push_back(r);
		endfunction

		function void note_beat(code_beat_t b);
			int child;
			int l;
			int r;
			if (b.command == CMD_WRITE) begin
				if (b.node_index < MAX_NODES) begin
					left_tbl[b.node_index] = b.left_child;
					right_tbl[b.node_index] = b.right_child;
					sym_tbl[b.node_index] = b.node_symbol[SYMBOL_BITS-1:0];
				end
				return;
			end
			if (walk_node >= MAX_NODES) begin
				emit('0, 1'b1);
				return;
			end
			child = b.code_bit ? right_tbl[walk_node] : left_tbl[walk_node];
			if (child < 0 || child >= MAX_NODES) begin
				emit('0, 1'b1);
				return;
			end
			l = left_tbl[child];
			r = right_tbl[child];
			if (l == -1 && r == -1)
				emit(sym_tbl[child], 1'b0);
			else if (l == -1 || r == -1)
				emit('0, 1'b1);
			else
				walk_node = NODE_AW'(child);
		endfunction

		function void check_pixel(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				note_error($sformatf("unexpected pixel beat: value %0h last %0b malformed %0b",
					got.pixel_value, got.last_of_image, got.malformed));
				return;
			end
			want = pending.pop_front();
			if (got.pixel_value !== want.pixel_value || got.last_of_image !== want.last_of_image
					|| got.malformed !== want.malformed)
				note_error($sformatf({"pixel mismatch: expected value %0h last %0b malformed %0b,",
					" got value %0h last %0b malformed %0b"}, want.pixel_value,
					want.last_of_image, want.malformed, got.pixel_value, got.last_of_image,
					got.malformed));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	htwd_in_if  code_ch();
	htwd_out_if pixel_ch();

	huffman_tree_walk_decoder_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.code    (code_ch),
		.pixel   (pixel_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pixel_scoreboard sb = new();
	bit              calm;
	int              fed;
	int              ready_gap;
	int              tree_nodes[$];
	code_beat_t      tree_beats[$];
	bit [31:0]       leaf_path[$];
	int              leaf_len[$];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always begin
		@(negedge clk);
		ready_gap = pick_gap();
		if (ready_gap == 0) begin
			pixel_ch.ready <= 1'b1;
		end else begin
			pixel_ch.ready <= 1'b0;
			repeat (ready_gap - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pixel_ch.valid && pixel_ch.ready)
			sb.check_pixel(res_t'{pixel_ch.pixel_value, pixel_ch.last_of_image,
				pixel_ch.malformed});
	end

	function automatic code_beat_t wr_beat(int idx, int l, int r, int sym);
		code_beat_t b;
		b.command = CMD_WRITE;
		b.node_index = NODE_AW'(idx);
		b.left_child = CHILD_W'(l);
		b.right_child = CHILD_W'(r);
		b.node_symbol = PIXEL_W'(sym);
		b.code_bit = 1'($urandom);
		return b;
	endfunction

	function automatic code_beat_t bit_beat(bit v);
		code_beat_t b;
		b.command = CMD_BIT;
		b.node_index = NODE_AW'($urandom);
		b.left_child = CHILD_W'($urandom);
		b.right_child = CHILD_W'($urandom);
		b.node_symbol = PIXEL_W'($urandom);
		b.code_bit = v;
		return b;
	endfunction

	function automatic int pick_child();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return -1;
		if (r < 70 && tree_nodes.size() > 0)
			return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
		return $urandom_range(0, 1023) - 512;
	endfunction

	function automatic code_beat_t noise_write();
		int idx;
		if (tree_nodes.size() > 0 && $urandom_range(0, 1))
			idx = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
		else
			idx = $urandom_range(0, 511);
		return wr_beat(idx, pick_child(), pick_child(), $urandom);
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(1, 9);
		if (r < 70)
			return $urandom_range(10, 300);
		if (r < 80)
			return 0;
		if (r < 90)
			return 24'hFFFFFF;
		return $urandom_range(0, 24'hFFFFFF);
	endfunction

	// grows a full binary tree from the root; leaf codes are kept LSB first
	function automatic void build_tree(int root, int n_leaves);
		bit        taken [MAX_NODES];
		int        open_idx[$];
		bit [31:0] open_bits[$];
		int        open_len[$];
		int        k;
		int        a;
		int        b;
		bit [31:0] pb;
		int        pl;
		foreach (taken[i])
			taken[i] = 1'b0;
		taken[root] = 1'b1;
		open_idx = '{root};
		open_bits = '{32'd0};
		open_len = '{0};
		tree_nodes = '{root};
		tree_beats.delete();
		while (open_idx.size() < n_leaves) begin
			k = $urandom_range(0, open_idx.size() - 1);
			do a = $urandom_range(0, MAX_NODES - 1); while (taken[a]);
			taken[a] = 1'b1;
			do b = $urandom_range(0, MAX_NODES - 1); while (taken[b]);
			taken[b] = 1'b1;
			tree_beats.push_back(wr_beat(open_idx[k], a, b, $urandom));
			pb = open_bits[k];
			pl = open_len[k];
			open_idx[k] = a;
			open_len[k] = pl + 1;
			open_idx.push_back(b);
			open_bits.push_back(pb | (32'd1 << pl));
			open_len.push_back(pl + 1);
			tree_nodes.push_back(a);
			tree_nodes.push_back(b);
		end
		foreach (open_idx[i])
			tree_beats.push_back(wr_beat(open_idx[i], NO_CHILD, NO_CHILD, $urandom));
		tree_beats.shuffle();
		leaf_path = open_bits;
		leaf_len = open_len;
	endfunction

	task automatic send_beat(input code_beat_t b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			code_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		code_ch.valid <= 1'b1;
		code_ch.command <= b.command;
		code_ch.node_index <= b.node_index;
		code_ch.left_child <= b.left_child;
		code_ch.right_child <= b.right_child;
		code_ch.node_symbol <= b.node_symbol;
		code_ch.code_bit <= b.code_bit;
		do @(posedge clk); while (!code_ch.ready);
		sb.note_beat(b);
		fed++;
	endtask

	task automatic send_code(int k, int len);
		for (int i = 0; i < len; i++)
			send_beat(bit_beat(leaf_path[k][i]));
	endtask

	task automatic apb_access(input bit wr, input logic idx, input logic [PDATA_W-1:0] data,
			output logic [PDATA_W-1:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= PADDR_W'(4 * idx);
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_check(input logic idx);
		logic [PDATA_W-1:0] rd;
		logic [PDATA_W-1:0] mask;
		mask = (idx == REG_ROOT) ? PDATA_W'((1 << NODE_AW) - 1) : PDATA_W'((1 << COUNT_W) - 1);
		apb_access(1'b0, idx, '0, rd);
		if ((rd & mask) !== sb.reg_value(idx))
			sb.note_error($sformatf("register %0d readback: expected %0h, got %0h", idx,
				sb.reg_value(idx), rd & mask));
	endtask

	task automatic reg_write(input logic idx, input int unsigned val);
		logic [PDATA_W-1:0] data;
		logic [PDATA_W-1:0] unused;
		int                 w;
		w = (idx == REG_ROOT) ? NODE_AW : COUNT_W;
		data = $urandom;
		data = (data << w) | PDATA_W'(val);
		apb_access(1'b1, idx, data, unused);
		sb.set_reg(idx, data);
		reg_check(idx);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		code_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(int root, int img, int n_leaves, int n_items, bit quiet);
		int  sent;
		int  r;
		int  k;
		int  len;
		bit  has_tree;
		wait_idle();
		reg_write(REG_ROOT, root);
		reg_write(REG_IMG, img);
		calm = quiet;
		sent = 0;
		has_tree = (root < MAX_NODES);
		tree_nodes.delete();
		if (has_tree) begin
			build_tree(root, n_leaves);
			foreach (tree_beats[i])
				send_beat(tree_beats[i]);
			sent = tree_beats.size();
		end
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (has_tree && r < 80) begin
				k = $urandom_range(0, leaf_len.size() - 1);
				send_code(k, leaf_len[k]);
				sent += leaf_len[k];
			end else if (has_tree && r < 87) begin
				k = $urandom_range(0, leaf_len.size() - 1);
				len = $urandom_range(1, leaf_len[k]);
				send_code(k, len);
				sent += len;
			end else if (r < 94) begin
				len = $urandom_range(1, 4);
				repeat (len) send_beat(bit_beat(1'($urandom)));
				sent += len;
			end else begin
				send_beat(noise_write());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		code_ch.valid = 1'b0;
		code_ch.command = CMD_WRITE;
		code_ch.node_index = '0;
		code_ch.left_child = '0;
		code_ch.right_child = '0;
		code_ch.node_symbol = '0;
		code_ch.code_bit = 1'b0;
		pixel_ch.ready = 1'b0;
		calm = 1'b0;
		fed = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		reg_check(REG_ROOT);
		reg_check(REG_IMG);

		// whole table as leaves, so no walk ever lands on an unwritten entry
		for (int i = 0; i < MAX_NODES; i++)
			send_beat(wr_beat(i, NO_CHILD, NO_CHILD, $urandom));

		// reset root is a leaf: missing child on both bits
		send_beat(bit_beat(1'b0));
		send_beat(bit_beat(1'b1));
		send_beat(wr_beat(511, 0, 0, 8'hAA));
		send_beat(wr_beat(0, NO_CHILD, NO_CHILD, 8'h00));
		send_beat(wr_beat(509, NO_CHILD, NO_CHILD, 8'hFF));
		send_beat(wr_beat(510, 0, 509, 8'h5A));
		send_beat(bit_beat(1'b0));
		send_beat(bit_beat(1'b1));
		// one child on the right, bad child indices at both ends
		send_beat(wr_beat(7, NO_CHILD, 0, 8'h11));
		send_beat(wr_beat(8, -512, 511, 8'h22));
		send_beat(wr_beat(510, 7, 8, 8'h33));
		send_beat(bit_beat(1'b0));
		send_beat(bit_beat(1'b1));
		send_beat(bit_beat(1'b0));
		send_beat(bit_beat(1'b1));
		send_beat(bit_beat(1'b1));
		// one child on the left, negative child other than none
		send_beat(wr_beat(8, 6, -2, 8'h44));
		send_beat(wr_beat(6, 509, NO_CHILD, 8'h55));
		send_beat(bit_beat(1'b1));
		send_beat(bit_beat(1'b0));
		send_beat(bit_beat(1'b1));
		send_beat(bit_beat(1'b1));
		send_beat(wr_beat(510, 0, 509, 8'h66));
		send_beat(bit_beat(1'b1));

		run_phase(0, 1, 2, 40, 1'b0);
		run_phase(510, 24'hFFFFFF, 12, 120, 1'b0);
		run_phase($urandom_range(0, 510), 3, 16, 120, 1'b1);
		run_phase($urandom_range(0, 510), 0, 6, 80, 1'b0);
		run_phase(511, 5, 0, 30, 1'b0);
		run_phase($urandom_range(0, 510), 2, 20, 100, 1'b0);
		while (fed < 1250)
			run_phase($urandom_range(0, 510), pick_size(), $urandom_range(2, 20),
				$urandom_range(60, 160), $urandom_range(0, 3) == 0);

		@(negedge clk);
		code_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/htwd_pkg.sv
rtl/core/htwd_if.sv
rtl/core/htwd_node_mem.sv
rtl/core/huffman_tree_walk_decoder_unit.sv
bench/tb_huffman_tree_walk_decoder_unit.sv
